### design/encoder_speed_pi_motor_control_core_defines.svh
// Assertion macros used by the checker of the encoder speed controller.
`ifndef ENCODER_SPEED_PI_MOTOR_CONTROL_CORE_DEFINES_SVH
`define ENCODER_SPEED_PI_MOTOR_CONTROL_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ESPI_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ESPI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/espi_pkg.sv
// Shared types, constants and codes of the encoder speed controller.
package espi_pkg;

	localparam int COUNTS_PER_REV_DEF = 420;
	localparam int SAMPLE_RATE_HZ_DEF = 10;
	localparam int COUNT_WIDTH_DEF    = 16;

	localparam int ANGLE_W    = 26;
	localparam int SPEED_W    = 17;
	localparam int DUTY_W     = 31;
	localparam int GAIN_W     = 24;
	localparam int TARGET_W   = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int NUM_STAGES = 7;

	localparam int SECONDS_PER_MIN = 60;

	localparam logic signed [ANGLE_W-1:0] ANGLE_STEP  = 26'sd56171;
	localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 26'sd23592960;
	localparam logic [DUTY_W-1:0]         DUTY_MAX    = 31'd1677721600;
	localparam logic [DUTY_W-1:0]         DUTY_RESET  = 31'd838860800;
	localparam logic [SPEED_W-1:0]        SPEED_MAX   = '1;
	localparam logic [GAIN_W-1:0]         PROP_GAIN_RESET  = 24'd134218;
	localparam logic [GAIN_W-1:0]         INTEG_GAIN_RESET = 24'd168;

	typedef enum logic {
		OP_EDGE = 1'b0,
		OP_TICK = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_RPM  = 2'd0,
		REG_REVERSE_DIR = 2'd1,
		REG_PROP_GAIN   = 2'd2,
		REG_INTEG_GAIN  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [TARGET_W-1:0] target_rpm;
		logic                reverse_direction;
		logic [GAIN_W-1:0]   prop_gain;
		logic [GAIN_W-1:0]   integral_gain;
	} cfg_t;

	// Part of a beat that rides along the pipeline unchanged after the front stage.
	typedef struct packed {
		opcode_t                   op;
		logic signed [ANGLE_W-1:0] angle;
		logic                      turning_reverse;
	} item_t;

	// ld[k]: stage k register loads this cycle; vld[k]: stage k holds a beat.
	typedef struct packed {
		logic [NUM_STAGES:1] ld;
		logic [NUM_STAGES:1] vld;
	} pipe_ctrl_t;

endpackage

### design/espi_encoder_front.sv
// Encoder front stage: angle tracking, direction and pulse counting.
module espi_encoder_front
	import espi_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pipe_ctrl_t             ctrl,
	input  opcode_t                op_s1,
	input  logic                   chb_s1,
	output item_t                  item_s2,
	output logic [COUNT_WIDTH-1:0] count_s2
);

	logic signed [ANGLE_W-1:0] angle_q;
	logic                      dir_q;
	logic [COUNT_WIDTH-1:0]    count_q;

	logic signed [ANGLE_W:0]   angle_sum;
	logic signed [ANGLE_W:0]   limit_ext;
	logic signed [ANGLE_W-1:0] angle_nxt;
	logic                      dir_nxt;
	logic [COUNT_WIDTH-1:0]    count_nxt;
	logic                      upd;

	assign upd = ctrl.ld[2] && ctrl.vld[1];

	always_comb begin
		limit_ext = (ANGLE_W+1)'(ANGLE_LIMIT);
		if (chb_s1) begin
			angle_sum = (ANGLE_W+1)'(angle_q) + (ANGLE_W+1)'(ANGLE_STEP);
		end else begin
			angle_sum = (ANGLE_W+1)'(angle_q) - (ANGLE_W+1)'(ANGLE_STEP);
		end
		angle_nxt = angle_q;
		dir_nxt   = dir_q;
		count_nxt = '0;
		if (op_s1 == OP_EDGE) begin
			// A full turn either way brings the angle back to zero.
			if ((angle_sum >= limit_ext) || (angle_sum <= -limit_ext)) begin
				angle_nxt = '0;
			end else begin
				angle_nxt = ANGLE_W'(angle_sum);
			end
			dir_nxt   = !chb_s1;
			count_nxt = (count_q == '1) ? count_q : count_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
			dir_q   <= 1'b0;
			count_q <= '0;
		end else if (upd) begin
			angle_q <= angle_nxt;
			dir_q   <= dir_nxt;
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld[2]) begin
			item_s2.op              <= op_s1;
			item_s2.angle           <= angle_nxt;
			item_s2.turning_reverse <= dir_nxt;
			count_s2                <= count_q;
		end
	end

endmodule

### design/espi_speed_calc.sv
// Pulse count to rpm conversion: scale, reciprocal multiply and saturation.
module espi_speed_calc
	import espi_pkg::*;
#(
	parameter int COUNTS_PER_REV = COUNTS_PER_REV_DEF,
	parameter int SAMPLE_RATE_HZ = SAMPLE_RATE_HZ_DEF,
	parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  pipe_ctrl_t             ctrl,
	input  item_t                  item_s2,
	input  logic [COUNT_WIDTH-1:0] count_s2,
	output item_t                  item_s5,
	output logic [SPEED_W-1:0]     rpm_s5
);

	localparam int RPM_SCALE = SECONDS_PER_MIN * SAMPLE_RATE_HZ;
	localparam int SCALE_W   = $clog2(RPM_SCALE + 1);
	localparam int PROD_W    = COUNT_WIDTH + SCALE_W;
	localparam int DIV_L     = $clog2(COUNTS_PER_REV);
	// Below saturation the scaled count stays under 2^SPEED_W * COUNTS_PER_REV.
	localparam int XL_W      = SPEED_W + DIV_L;
	localparam int RECIP_W   = SPEED_W + 1 + DIV_L;
	localparam int SHIFT     = SPEED_W + 2 * DIV_L;
	localparam int SPLIT     = SPEED_W;
	localparam int HI_W      = RECIP_W - SPLIT;
	localparam int FULL_W    = XL_W + RECIP_W;
	localparam logic [63:0] RECIP =
		((64'd1 << SHIFT) + 64'(COUNTS_PER_REV) - 64'd1) / 64'(COUNTS_PER_REV);
	localparam logic [63:0] SAT_LIM = 64'(COUNTS_PER_REV) << SPEED_W;
	localparam logic [SPLIT-1:0] RECIP_LO = RECIP[SPLIT-1:0];
	localparam logic [HI_W-1:0]  RECIP_HI = RECIP[RECIP_W-1:SPLIT];

	item_t                     item_s3;
	item_t                     item_s4;
	logic [PROD_W-1:0]         x_s3;
	logic                      sat_s4;
	logic [XL_W+SPLIT-1:0]     plo_s4;
	logic [XL_W+HI_W-1:0]      phi_s4;
	logic [XL_W-1:0]           x_low;
	logic [FULL_W-1:0]         full;
	logic [FULL_W-1:0]         quot;

	assign x_low = XL_W'(x_s3);

	always_comb begin
		full = (FULL_W'(phi_s4) << SPLIT) + FULL_W'(plo_s4);
		quot = full >> SHIFT;
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld[3]) begin
			item_s3 <= item_s2;
			x_s3    <= PROD_W'(count_s2) * PROD_W'(RPM_SCALE);
		end
		if (ctrl.ld[4]) begin
			item_s4 <= item_s3;
			sat_s4  <= 64'(x_s3) >= SAT_LIM;
			plo_s4  <= (XL_W+SPLIT)'(x_low) * (XL_W+SPLIT)'(RECIP_LO);
			phi_s4  <= (XL_W+HI_W)'(x_low) * (XL_W+HI_W)'(RECIP_HI);
		end
		if (ctrl.ld[5]) begin
			item_s5 <= item_s4;
			rpm_s5  <= sat_s4 ? SPEED_MAX : SPEED_W'(quot);
		end
	end

endmodule

### design/espi_duty_ctrl.sv
// Speed error, duty step, clamp and the result register with speed and duty state.
module espi_duty_ctrl
	import espi_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  pipe_ctrl_t                ctrl,
	input  cfg_t                      cfg,
	input  item_t                     item_s5,
	input  logic [SPEED_W-1:0]        rpm_s5,
	output logic signed [ANGLE_W-1:0] angle,
	output logic [SPEED_W-1:0]        speed_rpm,
	output logic [DUTY_W-1:0]         duty,
	output logic                      turning_reverse
);

	localparam int ERR_W  = SPEED_W + 1;
	localparam int GSW    = GAIN_W + 2;
	localparam int STEP_W = GSW + ERR_W;
	localparam int SUM_W  = STEP_W + 1;

	item_t                    item_s6;
	logic [SPEED_W-1:0]       rpm_s6;
	logic signed [STEP_W-1:0] step_s6;

	logic signed [ERR_W-1:0]  rpm_ext;
	logic signed [ERR_W-1:0]  tgt_ext;
	logic signed [ERR_W-1:0]  err;
	logic signed [GSW-1:0]    gain;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  max_ext;
	logic [DUTY_W-1:0]        duty_nxt;

	always_comb begin
		rpm_ext = signed'({1'b0, rpm_s5});
		tgt_ext = signed'(ERR_W'(cfg.target_rpm));
		// Error sign follows the wanted direction.
		if (cfg.reverse_direction) begin
			err = tgt_ext - rpm_ext;
		end else begin
			err = rpm_ext - tgt_ext;
		end
		gain = signed'(GSW'(cfg.prop_gain) + GSW'(cfg.integral_gain));
	end

	always_comb begin
		max_ext = signed'(SUM_W'(DUTY_MAX));
		sum     = signed'(SUM_W'(duty)) + SUM_W'(step_s6);
		if (sum > max_ext) begin
			duty_nxt = DUTY_MAX;
		end else if (sum < 0) begin
			duty_nxt = '0;
		end else begin
			duty_nxt = DUTY_W'(sum);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld[6]) begin
			item_s6 <= item_s5;
			rpm_s6  <= rpm_s5;
			step_s6 <= STEP_W'(gain) * STEP_W'(err);
		end
		if (ctrl.ld[7]) begin
			angle           <= item_s6.angle;
			turning_reverse <= item_s6.turning_reverse;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_rpm <= '0;
			duty      <= DUTY_RESET;
		end else if (ctrl.ld[7] && ctrl.vld[6] && (item_s6.op == OP_TICK)) begin
			speed_rpm <= rpm_s6;
			duty      <= duty_nxt;
		end
	end

endmodule

### design/encoder_speed_pi_motor_control_core.sv
// Top level of the encoder speed measurement and incremental PI speed controller.
//
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_ready    opcode, channel_b_level
// result    out        out_valid/out_ready  angle, speed_rpm, duty, turning_reverse
// config    in         cfg_wr_en            cfg_index, cfg_wdata
//
// The block takes one beat per cycle while in_ready is high and gives one result beat
// per input beat. A result passes through seven register stages; the scaled count feeds
// a split reciprocal multiply and then the gain multiply.
// Reset clears the angle, pulse count, speed and direction, sets the duty to 50 percent
// and loads the default gains. No clearing pass is needed.
// Each stage moves on when it is empty or the stage after it moves, so bubbles close up
// and in_ready only drops while every stage is full and the result beat is held.
module encoder_speed_pi_motor_control_core
	import espi_pkg::*;
#(
	parameter int COUNTS_PER_REV = COUNTS_PER_REV_DEF,
	parameter int SAMPLE_RATE_HZ = SAMPLE_RATE_HZ_DEF,
	parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      opcode,
	input  logic                      channel_b_level,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [ANGLE_W-1:0] angle,
	output logic [SPEED_W-1:0]        speed_rpm,
	output logic [DUTY_W-1:0]         duty,
	output logic                      turning_reverse,
	input  logic                      cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_wdata
);

	cfg_t                   cfg_q;
	logic [NUM_STAGES:1]    vld_q;
	logic [NUM_STAGES+1:1]  adv;
	pipe_ctrl_t             ctrl;

	opcode_t                op_s1;
	logic                   chb_s1;
	item_t                  item_s2;
	logic [COUNT_WIDTH-1:0] count_s2;
	item_t                  item_s5;
	logic [SPEED_W-1:0]     rpm_s5;

	// Config registers. The user makes writes only while the block is idle; unchecked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_rpm        <= '0;
			cfg_q.reverse_direction <= 1'b0;
			cfg_q.prop_gain         <= PROP_GAIN_RESET;
			cfg_q.integral_gain     <= INTEG_GAIN_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_TARGET_RPM:  cfg_q.target_rpm        <= TARGET_W'(cfg_wdata);
				REG_REVERSE_DIR: cfg_q.reverse_direction <= cfg_wdata[0];
				REG_PROP_GAIN:   cfg_q.prop_gain         <= GAIN_W'(cfg_wdata);
				REG_INTEG_GAIN:  cfg_q.integral_gain     <= GAIN_W'(cfg_wdata);
				default: ;
			endcase
		end
	end

	// Advance chain, from the result register back to the input register.
	always_comb begin
		adv[NUM_STAGES+1] = out_ready;
		for (int k = NUM_STAGES; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
		ctrl.ld  = adv[NUM_STAGES:1];
		ctrl.vld = vld_q;
	end

	assign in_ready  = adv[1];
	assign out_valid = vld_q[NUM_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			op_s1  <= opcode_t'(opcode);
			chb_s1 <= channel_b_level;
		end
	end

	espi_encoder_front #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.op_s1    (op_s1),
		.chb_s1   (chb_s1),
		.item_s2  (item_s2),
		.count_s2 (count_s2)
	);

	espi_speed_calc #(
		.COUNTS_PER_REV (COUNTS_PER_REV),
		.SAMPLE_RATE_HZ (SAMPLE_RATE_HZ),
		.COUNT_WIDTH    (COUNT_WIDTH)
	) u_speed (
		.clk      (clk),
		.ctrl     (ctrl),
		.item_s2  (item_s2),
		.count_s2 (count_s2),
		.item_s5  (item_s5),
		.rpm_s5   (rpm_s5)
	);

	espi_duty_ctrl u_duty (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (ctrl),
		.cfg             (cfg_q),
		.item_s5         (item_s5),
		.rpm_s5          (rpm_s5),
		.angle           (angle),
		.speed_rpm       (speed_rpm),
		.duty            (duty),
		.turning_reverse (turning_reverse)
	);

endmodule

### design/espi_checker.sv
// Port-level checker of the encoder speed controller and its bind.
`include "encoder_speed_pi_motor_control_core_defines.svh"

module espi_checker
	import espi_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [ANGLE_W-1:0] angle,
	input logic [SPEED_W-1:0]        speed_rpm,
	input logic [DUTY_W-1:0]         duty,
	input logic                      turning_reverse
);

	// A held result beat stays put until it is taken.
	`ESPI_ASSERT_NEXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(angle) && $stable(speed_rpm) && $stable(duty) && $stable(turning_reverse), "result beat changed while stalled")

	// Back-pressure on the input only comes from a stalled result beat.
	`ESPI_ASSERT_SAME(a_ready_cause, !in_ready, out_valid && !out_ready, "input stalled without a held result")

	// A result beat carries a clamped duty and an angle inside one turn.
	`ESPI_ASSERT_SAME(a_result_range, out_valid, (duty <= DUTY_MAX) && (angle < ANGLE_LIMIT) && (angle > -ANGLE_LIMIT), "result beat out of range")

endmodule

bind encoder_speed_pi_motor_control_core espi_checker u_checker (.*);

### bench/espi_speed_checker.sv
`timescale 1ns / 1ps
// Result predictor and comparator for the encoder speed controller, watching its channels.
module espi_speed_checker
	import espi_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic                  opcode,
	input  logic                  channel_b_level,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [ANGLE_W-1:0]    angle,
	input  logic [SPEED_W-1:0]    speed_rpm,
	input  logic [DUTY_W-1:0]     duty,
	input  logic                  turning_reverse,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    failures,
	output int                    pending,
	output int                    edge_beats,
	output int                    tick_beats,
	output int                    angle_wraps,
	output int                    duty_clamps,
	output int                    count_saturations
);

	localparam longint DEG_STEP_Q16  = 56171;
	localparam longint FULL_TURN_Q16 = 360 * 65536;
	localparam longint DUTY_FULL     = 100 * 16777216;
	localparam longint DUTY_HALF     = 50 * 16777216;
	localparam longint RPM_CEIL      = 131071;
	localparam longint PULSES_PER_REV = 420;
	localparam longint TICKS_PER_SEC  = 10;
	localparam logic [15:0] PULSE_CEIL = 16'hFFFF;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] angle;
		logic [SPEED_W-1:0]        speed;
		logic [DUTY_W-1:0]         duty;
		logic                      rev;
	} motor_state_t;

	logic [TARGET_W-1:0]       target;
	logic                      rev_wanted;
	logic [GAIN_W-1:0]         kp;
	logic [GAIN_W-1:0]         ki;
	logic signed [ANGLE_W-1:0] angle_q16;
	logic [15:0]               pulses;
	logic [SPEED_W-1:0]        speed;
	logic [DUTY_W-1:0]         duty_q24;
	logic                      dir_rev;
	motor_state_t              due_results[$];

	// Advances the controller state by one input beat and returns the state it reports.
	function automatic motor_state_t step_controller(opcode_t op, logic b_level);
		longint       a;
		longint       rpm;
		longint       err;
		longint       d;
		motor_state_t r;
		if (op == OP_EDGE) begin
			edge_beats++;
			a = longint'(angle_q16);
			if (b_level) begin
				a += DEG_STEP_Q16;
				dir_rev = 1'b0;
			end else begin
				a -= DEG_STEP_Q16;
				dir_rev = 1'b1;
			end
			if (a >= FULL_TURN_Q16 || a <= -FULL_TURN_Q16) begin
				a = 0;
				angle_wraps++;
			end
			angle_q16 = a[ANGLE_W-1:0];
			if (pulses == PULSE_CEIL)
				count_saturations++;
			else
				pulses++;
		end else begin
			tick_beats++;
			rpm = longint'(pulses) * 60 * TICKS_PER_SEC / PULSES_PER_REV;
			if (rpm > RPM_CEIL)
				rpm = RPM_CEIL;
			speed = rpm[SPEED_W-1:0];
			pulses = '0;
			// The error sign follows the wanted direction as the controller defines it.
			err = rev_wanted ? longint'(target) - rpm : rpm - longint'(target);
			d = longint'(duty_q24) + (longint'(kp) + longint'(ki)) * err;
			if (d > DUTY_FULL) begin
				d = DUTY_FULL;
				duty_clamps++;
			end else if (d < 0) begin
				d = 0;
				duty_clamps++;
			end
			duty_q24 = d[DUTY_W-1:0];
		end
		r.angle = angle_q16;
		r.speed = speed;
		r.duty  = duty_q24;
		r.rev   = dir_rev;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		motor_state_t got;
		motor_state_t want;
		if (!arst_n) begin
			target            = '0;
			rev_wanted        = 1'b0;
			kp                = 24'd134218;
			ki                = 24'd168;
			angle_q16         = '0;
			pulses            = '0;
			speed             = '0;
			duty_q24          = DUTY_HALF[DUTY_W-1:0];
			dir_rev           = 1'b0;
			failures          = 0;
			edge_beats        = 0;
			tick_beats        = 0;
			angle_wraps       = 0;
			duty_clamps       = 0;
			count_saturations = 0;
			due_results.delete();
			pending <= 0;
		end else begin
			// Results leave before new beats enter, so a beat never meets its own result here.
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				got.angle = angle;
				got.speed = speed_rpm;
				got.duty  = duty;
				got.rev   = turning_reverse;
				if (due_results.size() == 0) begin
					$error("result beat with nothing outstanding: angle %0d speed %0d duty %0d",
						got.angle, got.speed, got.duty);
					failures++;
				end else begin
					want = due_results.pop_front();
					if (got.angle !== want.angle) begin
						$error("angle: expected %0d, got %0d", want.angle, got.angle);
						failures++;
					end
					if (got.speed !== want.speed) begin
						$error("speed_rpm: expected %0d, got %0d", want.speed, got.speed);
						failures++;
					end
					if (got.duty !== want.duty) begin
						$error("duty: expected %0d, got %0d", want.duty, got.duty);
						failures++;
					end
					if (got.rev !== want.rev) begin
						$error("turning_reverse: expected %0b, got %0b", want.rev, got.rev);
						failures++;
					end
				end
			end
			if (cfg_wr_en === 1'b1) begin
				case (cfg_reg_t'(cfg_index))
					REG_TARGET_RPM:  target     = cfg_wdata[TARGET_W-1:0];
					REG_REVERSE_DIR: rev_wanted = cfg_wdata[0];
					REG_PROP_GAIN:   kp         = cfg_wdata[GAIN_W-1:0];
					REG_INTEG_GAIN:  ki         = cfg_wdata[GAIN_W-1:0];
					default: ;
				endcase
			end
			if (in_valid === 1'b1 && in_ready === 1'b1)
				due_results.push_back(step_controller(opcode_t'(opcode), channel_b_level));
			pending <= due_results.size();
		end
	end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the encoder speed controller testbench: clock, reset, stimulus and verdict.
module tb_top;
	import espi_pkg::*;

	// Default gains, used again when a phase returns the controller to its reset tuning.
	localparam logic [GAIN_W-1:0] KP_DEFAULT = 24'd134218;
	localparam logic [GAIN_W-1:0] KI_DEFAULT = 24'd168;

	// A long run of anticlockwise edges; starting three steps clockwise of zero, it carries
	// the angle past minus 360 degrees, where it returns to zero.
	localparam int WRAP_RUN = 430;

	logic                  clk             = 1'b0;
	logic                  arst_n          = 1'b0;
	logic                  in_valid        = 1'b0;
	logic                  in_ready;
	logic                  opcode          = 1'b0;
	logic                  channel_b_level = 1'b0;
	logic                  out_valid;
	logic                  out_ready       = 1'b0;
	logic [ANGLE_W-1:0]    angle;
	logic [SPEED_W-1:0]    speed_rpm;
	logic [DUTY_W-1:0]     duty;
	logic                  turning_reverse;
	logic                  cfg_wr_en       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index       = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata       = '0;

	int failures;
	int pending;
	int edge_beats;
	int tick_beats;
	int angle_wraps;
	int duty_clamps;
	int count_saturations;

	// When set, the sender never leaves a gap between beats, or the receiver never stalls.
	bit tx_free  = 1'b0;
	bit rx_free  = 1'b0;
	int rx_hold  = 0;
	int settings = 0;

	encoder_speed_pi_motor_control_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.opcode          (opcode),
		.channel_b_level (channel_b_level),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.angle           (angle),
		.speed_rpm       (speed_rpm),
		.duty            (duty),
		.turning_reverse (turning_reverse),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata)
	);

	espi_speed_checker u_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.opcode            (opcode),
		.channel_b_level   (channel_b_level),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.angle             (angle),
		.speed_rpm         (speed_rpm),
		.duty              (duty),
		.turning_reverse   (turning_reverse),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.failures          (failures),
		.pending           (pending),
		.edge_beats        (edge_beats),
		.tick_beats        (tick_beats),
		.angle_wraps       (angle_wraps),
		.duty_clamps       (duty_clamps),
		.count_saturations (count_saturations)
	);

	// 125 MHz clock: 4 ns high, 4 ns low.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Result-side back-pressure. Each choice holds for a random number of cycles: mostly
	// ready, often a short stall, and now and then a long one so that the pipeline fills
	// and in_ready drops.
	always @(posedge clk) begin
		int roll;
		if (rx_free) begin
			out_ready <= 1'b1;
			rx_hold   <= 0;
		end else if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
		end else begin
			roll = $urandom_range(99);
			if (roll < 65) begin
				out_ready <= 1'b1;
				rx_hold   <= $urandom_range(7);
			end else if (roll < 95) begin
				out_ready <= 1'b0;
				rx_hold   <= $urandom_range(2);
			end else begin
				out_ready <= 1'b0;
				rx_hold   <= $urandom_range(40, 10);
			end
		end
	end

	// Cycles of silence after a beat on the input side: mostly none, some short, few long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (tx_free || roll < 70)
			return 0;
		if (roll < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Mostly the reset tuning, zero, full scale or modest values, sometimes any value.
	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(4))
			0:       return KP_DEFAULT;
			1:       return '0;
			2:       return '1;
			3:       return GAIN_W'($urandom_range(1 << 20));
			default: return GAIN_W'($urandom);
		endcase
	endfunction

	// Software writes 0 or 10..50, but every 6-bit value is allowed through unchanged.
	function automatic logic [TARGET_W-1:0] pick_target();
		int roll;
		roll = $urandom_range(99);
		if (roll < 10)
			return '0;
		if (roll < 75)
			return TARGET_W'($urandom_range(50, 10));
		return TARGET_W'($urandom_range(63));
	endfunction

	// Offers one beat, holds it until it is taken, then leaves a random gap.
	task automatic send_beat(input opcode_t op, input logic b_level);
		int gap;
		in_valid        <= 1'b1;
		opcode          <= op;
		channel_b_level <= b_level;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops sending and waits until every result beat has come back. The pipeline is seven
	// stages deep, and the extra wait at the end leaves it empty before any register write.
	task automatic settle();
		int guard;
		in_valid <= 1'b0;
		@(posedge clk);
		guard = 0;
		while (pending != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// Loads all four registers back to back. The narrow registers get random upper bits,
	// which the block has to drop.
	task automatic load_settings(input logic [TARGET_W-1:0] tgt, input logic rev,
			input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom);
		write_reg(REG_TARGET_RPM, {junk[CFG_DATA_W-1:TARGET_W], tgt});
		junk = CFG_DATA_W'($urandom);
		write_reg(REG_REVERSE_DIR, {junk[CFG_DATA_W-1:1], rev});
		write_reg(REG_PROP_GAIN, kp);
		write_reg(REG_INTEG_GAIN, ki);
		cfg_wr_en <= 1'b0;
		settings++;
	endtask

	// A phase of realistic traffic: bursts of encoder edges that mostly keep one direction,
	// each closed by a sampling tick. Some edges flip direction as noise, some ticks come
	// with no edges before them, and now and then the sender waits for the pipeline to empty.
	task automatic run_phase(input int n_items);
		int   sent;
		int   burst;
		int   roll;
		int   k;
		logic dir;
		sent = 0;
		while (sent < n_items) begin
			roll = $urandom_range(99);
			if (roll < 10)
				burst = 0;
			else if (roll < 35)
				burst = $urandom_range(4, 1);
			else if (roll < 95)
				burst = $urandom_range(40, 5);
			else
				burst = $urandom_range(100, 41);
			dir = 1'($urandom_range(1));
			for (k = 0; k < burst; k++) begin
				send_beat(OP_EDGE, ($urandom_range(99) < 88) ? dir : ~dir);
				sent++;
				if ($urandom_range(199) == 0)
					settle();
			end
			send_beat(OP_TICK, 1'($urandom_range(1)));
			sent++;
			if ($urandom_range(9) == 0) begin
				send_beat(OP_TICK, 1'($urandom_range(1)));
				sent++;
			end
		end
	endtask

	initial begin : stimulus
		int p;
		int k;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Reset tuning. A tick with no pulses gives zero speed and, with a zero target,
		// leaves the duty at half. Then five encoder steps in both directions and a tick that turns
		// them into rpm, and a tick right after it that finds the count cleared.
		send_beat(OP_TICK, 1'b1);
		send_beat(OP_EDGE, 1'b1);
		send_beat(OP_EDGE, 1'b0);
		send_beat(OP_EDGE, 1'b1);
		send_beat(OP_EDGE, 1'b1);
		send_beat(OP_EDGE, 1'b1);
		send_beat(OP_TICK, 1'b0);
		send_beat(OP_TICK, 1'b1);

		// Angle wrap at full rate: the angle stands three steps clockwise of zero, and the
		// anticlockwise run takes it past minus 360 degrees. The tick that follows turns the
		// whole run into one large speed reading.
		tx_free = 1'b1;
		rx_free <= 1'b1;
		for (k = 0; k < WRAP_RUN; k++)
			send_beat(OP_EDGE, 1'b0);
		send_beat(OP_TICK, 1'b0);
		send_beat(OP_TICK, 1'b1);
		tx_free = 1'b0;
		rx_free <= 1'b0;

		// Largest target, written past the software range, with full-scale gains: a
		// stopped motor drives the duty hard into its lower clamp and holds it there.
		settle();
		load_settings('1, 1'b0, '1, '1);
		send_beat(OP_TICK, 1'b0);
		send_beat(OP_EDGE, 1'b0);
		send_beat(OP_EDGE, 1'b0);
		send_beat(OP_TICK, 1'b1);

		// Reverse wanted direction flips the error sign, so the same speeds now push the
		// duty to its upper clamp, twice in a row.
		settle();
		load_settings('1, 1'b1, '1, '1);
		send_beat(OP_TICK, 1'b0);
		send_beat(OP_TICK, 1'b1);

		// Zero gains: the duty must not move whatever the error.
		settle();
		load_settings(6'd20, 1'b1, '0, '0);
		send_beat(OP_EDGE, 1'b1);
		send_beat(OP_TICK, 1'b0);

		// Random phases. Phase 3 runs with no idling on either side; the others idle both
		// sides at random. The first four use fixed register settings, the rest random ones.
		for (p = 0; p < 8; p++) begin
			settle();
			case (p)
				0:       load_settings('0, 1'b0, KP_DEFAULT, KI_DEFAULT);
				1:       load_settings(6'd50, 1'b1, '1, '1);
				2:       load_settings(6'd63, 1'b0, '0, '0);
				3:       load_settings(6'd10, 1'b0, KP_DEFAULT, KI_DEFAULT);
				default: load_settings(pick_target(), 1'($urandom_range(1)), pick_gain(),
					pick_gain());
			endcase
			tx_free = (p == 3);
			rx_free <= (p == 3);
			run_phase(40);
		end
		tx_free = 1'b0;
		rx_free <= 1'b0;

		// Drain, then give the block some quiet cycles to show any stray result beat.
		settle();
		repeat (20) @(posedge clk);

		if (pending != 0)
			$error("%0d result beats never arrived", pending);
		$display("tb_top: %0d encoder edges and %0d sampling ticks over %0d register settings",
			edge_beats, tick_beats, settings);
		$display("tb_top: %0d angle wraps, %0d duty clamps, %0d edges at the count ceiling",
			angle_wraps, duty_clamps, count_saturations);
		if (failures == 0 && pending == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// Watchdog: the slowest correct run is well under a tenth of this.
	initial begin
		#20000000;
		$display("tb_top: watchdog expired with %0d result beats outstanding", pending);
		$display("tb_top: FAIL");
		$finish;
	end

endmodule

### files.f
+incdir+design
design/espi_pkg.sv
design/espi_encoder_front.sv
design/espi_speed_calc.sv
design/espi_duty_ctrl.sv
design/encoder_speed_pi_motor_control_core.sv
design/espi_checker.sv
bench/espi_speed_checker.sv
bench/tb_top.sv
